@@ hdl/hsc_pkg.sv @@
// Package for the Hamming SEC codec: word types, register codes and bit helpers.
// Depends on nothing; used by hamming_sec_codec.
`default_nettype none

package hsc_pkg;

   localparam int CODE_W = 63;
   localparam int SYN_W  = 6;
   localparam int LEN_W  = 6;

   // Register index codes
   localparam logic CSR_DATA_LEN = 1'b0;

   // Operation codes
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [CODE_W-1:0] in_bits;
   } req_word_type;

   typedef struct packed {
      logic [CODE_W-1:0] result_bits;
      logic [SYN_W-1:0]  syndrome;
      logic              decode_error;
   } rsp_word_type;

   // Values derived from data_len, kept so the datapath never recomputes them
   typedef struct packed {
      logic [CODE_W-1:0] m_mask;
      logic [CODE_W-1:0] n_mask;
      logic [SYN_W-1:0]  n;
   } cfg_derived_type;

   // Least r with 2^r >= m + r + 1, capped at 7
   function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] m);
      logic [2:0] r;
      r = 3'd1;
      for (int k = 1; k < 7; k++) begin
         if ((8'd1 << r) < (8'(m) + 8'(r) + 8'd1)) begin
            r = r + 3'd1;
         end
      end
      return r;
   endfunction

   // Largest data length whose codeword fits in max_code bits (elaboration only)
   function automatic int max_data_len(input int max_code);
      int best;
      best = 1;
      for (int m = 1; m < 64; m++) begin
         if (m + int'(parity_count(LEN_W'(m))) <= max_code) begin
            best = m;
         end
      end
      return best;
   endfunction

   function automatic cfg_derived_type derive(input logic [LEN_W-1:0] len,
                                              input logic [LEN_W-1:0] max_m);
      cfg_derived_type d;
      logic [LEN_W-1:0] m;
      logic [2:0]       r;
      m = (len == '0) ? LEN_W'(1) : len;
      if (m > max_m) begin
         m = max_m;
      end
      r = parity_count(m);
      d.n      = m + SYN_W'(r);
      d.m_mask = ~({CODE_W{1'b1}} << m);
      d.n_mask = ~({CODE_W{1'b1}} << d.n);
      return d;
   endfunction

   // Data bit k goes to the k-th non-power-of-two position; pure wiring
   function automatic logic [CODE_W-1:0] scatter(input logic [CODE_W-1:0] d);
      logic [CODE_W-1:0] w;
      int idx;
      w   = '0;
      idx = 0;
      for (int p = 1; p <= CODE_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            w[p-1] = d[idx];
            idx++;
         end
      end
      return w;
   endfunction

   function automatic logic [CODE_W-1:0] gather(input logic [CODE_W-1:0] w);
      logic [CODE_W-1:0] d;
      int idx;
      d   = '0;
      idx = 0;
      for (int p = 1; p <= CODE_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            d[idx] = w[p-1];
            idx++;
         end
      end
      return d;
   endfunction

   // XOR of the 1-based positions of all set bits: one parity tree per syndrome bit
   function automatic logic [SYN_W-1:0] position_xor(input logic [CODE_W-1:0] w);
      logic [SYN_W-1:0] s;
      s = '0;
      for (int i = 0; i < SYN_W; i++) begin
         for (int p = 1; p <= CODE_W; p++) begin
            if (((p >> i) & 1) != 0) begin
               s[i] = s[i] ^ w[p-1];
            end
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

@@ hdl/hamming_sec_codec.sv @@
// Hamming SEC codec top level: APB register, three-stage encode/decode pipeline.
// Depends on hsc_pkg (word types, derive, scatter, gather, position_xor).
// An accepted word passes the stage A, B and C registers in turn before its result strobe rsp_valid.
// Throughput: one word per cycle; busy is never raised since the receiver cannot stall.
// Stages: mask/scatter, syndrome XOR trees, correction/gather and output register.
// Reset (synchronous): pipeline emptied, data_len back to 4.
`default_nettype none

module hamming_sec_codec #(
   parameter int MAX_CODE_BITS = 63
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   start,
   output logic                  busy,
   input  hsc_pkg::req_word_type req_word,
   // result channel
   output logic                  rsp_valid,
   output hsc_pkg::rsp_word_type rsp_word,
   // register port
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [2:0]            csr_paddr,
   input  wire  [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam logic [hsc_pkg::LEN_W-1:0] MAX_M =
      hsc_pkg::LEN_W'(hsc_pkg::max_data_len(MAX_CODE_BITS));
   localparam logic [hsc_pkg::LEN_W-1:0] LEN_RESET = hsc_pkg::LEN_W'(4);

   logic [hsc_pkg::LEN_W-1:0] data_len_ff;
   hsc_pkg::cfg_derived_type  cfg_ff;
   logic                      csr_wr;

   // stage A: masked codeword or scattered data
   logic                          va_ff, opa_ff;
   logic [hsc_pkg::CODE_W-1:0]    wa_ff, wa_in;
   // stage B: word plus its position XOR
   logic                          vb_ff, opb_ff;
   logic [hsc_pkg::CODE_W-1:0]    wb_ff;
   logic [hsc_pkg::SYN_W-1:0]     sb_ff;
   // stage C: result register
   logic                          vc_ff, opc_ff;
   hsc_pkg::rsp_word_type         rc_ff, rc_in;

   logic [hsc_pkg::CODE_W-1:0]    flip, fixed_w;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == hsc_pkg::CSR_DATA_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         data_len_ff <= LEN_RESET;
         cfg_ff      <= hsc_pkg::derive(LEN_RESET, MAX_M);
      end else if (csr_wr) begin
         data_len_ff <= csr_pwdata[hsc_pkg::LEN_W-1:0];
         cfg_ff      <= hsc_pkg::derive(csr_pwdata[hsc_pkg::LEN_W-1:0], MAX_M);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == hsc_pkg::CSR_DATA_LEN) begin
         csr_prdata = {{(32 - hsc_pkg::LEN_W){1'b0}}, data_len_ff};
      end
   end

   // ---------------- pipeline ----------------
   assign busy = 1'b0;

   always_comb begin
      if (req_word.req_type == hsc_pkg::OP_DECODE) begin
         wa_in = req_word.in_bits & cfg_ff.n_mask;
      end else begin
         wa_in = hsc_pkg::scatter(req_word.in_bits & cfg_ff.m_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= start && !busy;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff <= req_word.req_type;
      wa_ff  <= wa_in;
      opb_ff <= opa_ff;
      wb_ff  <= wa_ff;
      sb_ff  <= hsc_pkg::position_xor(wa_ff);
      opc_ff <= opb_ff;
      rc_ff  <= rc_in;
   end

   // one-hot flip vector; zero when the syndrome is zero
   always_comb begin
      for (int p = 1; p <= hsc_pkg::CODE_W; p++) begin
         flip[p-1] = (sb_ff == hsc_pkg::SYN_W'(p));
      end
      fixed_w = wb_ff ^ flip;
   end

   always_comb begin
      rc_in = '0;
      if (opb_ff == hsc_pkg::OP_DECODE) begin
         rc_in.syndrome = sb_ff;
         if (sb_ff > cfg_ff.n) begin
            rc_in.decode_error = 1'b1;
         end else begin
            rc_in.result_bits = hsc_pkg::gather(fixed_w);
         end
      end else begin
         rc_in.result_bits = wb_ff;
         for (int i = 0; i < hsc_pkg::SYN_W; i++) begin
            rc_in.result_bits[(1 << i) - 1] = sb_ff[i];
         end
      end
   end

   assign rsp_valid = vc_ff;
   assign rsp_word  = rc_ff;

   // ---------------- assertions ----------------
   a_encode_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (opc_ff == hsc_pkg::OP_ENCODE) |->
         (hsc_pkg::position_xor(rsp_word.result_bits) == '0)
         && (rsp_word.syndrome == '0) && !rsp_word.decode_error)
      else $error("encoded word does not check clean");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.decode_error |->
         (rsp_word.result_bits == '0) && (rsp_word.syndrome > cfg_ff.n))
      else $error("decode error with non-zero data or in-range syndrome");

   a_no_stray_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_word.result_bits & ~((opc_ff == hsc_pkg::OP_DECODE) ?
            cfg_ff.m_mask : cfg_ff.n_mask)) == '0))
      else $error("result has bits beyond its length");

endmodule

`default_nettype wire
